// ===== design/imc_pkg.sv =====
package imc_pkg;

  // default build values
  localparam int DefCalSamples = 100;
  localparam int DefFracBits   = 8;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_GYRO_RANGE  = 3'd0,
    REG_ACCEL_RANGE = 3'd1,
    REG_ROTATE_THR  = 3'd2,
    REG_STILL_THR   = 3'd3,
    REG_GRAV_TOL    = 3'd4,
    REG_TILT_TOL    = 3'd5,
    REG_AXIS_THR    = 3'd6
  } cfg_reg_e;

  // motion classes
  typedef enum logic [2:0] {
    CLS_STILL    = 3'd0,
    CLS_TILTED   = 3'd1,
    CLS_ROTATING = 3'd2,
    CLS_MOVE_X   = 3'd3,
    CLS_MOVE_Y   = 3'd4,
    CLS_MOVING   = 3'd5,
    CLS_CALIB    = 3'd6
  } motion_class_e;

  // led colours
  typedef enum logic [2:0] {
    LED_OFF     = 3'd0,
    LED_RED     = 3'd1,
    LED_GREEN   = 3'd2,
    LED_YELLOW  = 3'd3,
    LED_BLUE    = 3'd4,
    LED_MAGENTA = 3'd5,
    LED_WHITE   = 3'd7
  } led_color_e;

  localparam int RegW = 19;

  // accel full scale in m/s^2, truncated
  function automatic logic [7:0] accel_full_scale(input logic [1:0] sel);
    logic [7:0] r;
    case (sel)
      2'd0: r = 8'd19;
      2'd1: r = 8'd39;
      2'd2: r = 8'd78;
      default: r = 8'd156;
    endcase
    return r;
  endfunction

  // gyro lsb per deg/s, times ten
  function automatic logic [10:0] gyro_div(input logic [1:0] sel);
    logic [10:0] r;
    case (sel)
      2'd0: r = 11'd1310;
      2'd1: r = 11'd655;
      2'd2: r = 11'd328;
      default: r = 11'd164;
    endcase
    return r;
  endfunction

  function automatic led_color_e color_of(input motion_class_e c);
    led_color_e r;
    case (c)
      CLS_STILL:    r = LED_OFF;
      CLS_TILTED:   r = LED_RED;
      CLS_ROTATING: r = LED_BLUE;
      CLS_MOVE_X:   r = LED_YELLOW;
      CLS_MOVE_Y:   r = LED_MAGENTA;
      CLS_MOVING:   r = LED_GREEN;
      default:      r = LED_WHITE;
    endcase
    return r;
  endfunction

endpackage

// ===== design/imc_div.sv =====
module imc_div #(
  parameter int NUMW = 45,
  parameter int DENW = 24,
  parameter int QW   = 21
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NUMW-1:0] num_i,
  input  logic        [DENW-1:0] den_i,
  output logic                   done_o,
  output logic signed [QW:0]     quot_o
);

  localparam int RW   = (NUMW > DENW + QW) ? NUMW : DENW + QW;
  localparam int CNTW = $clog2(QW + 1);

  logic            busy_q, done_q, neg_q;
  logic [CNTW-1:0] cnt_q;
  logic [RW-1:0]   rem_q, ds_q;
  logic [QW-1:0]   q_q;
  logic [NUMW-1:0] num_mag;
  logic            ge;
  logic [QW:0]     q_ext;

  // magnitude of the dividend and the trial compare
  always_comb begin
    num_mag = num_i[NUMW-1] ? NUMW'(-num_i) : NUMW'(num_i);
    ge      = rem_q >= ds_q;
  end

  // control, one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring division datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NUMW-1];
      rem_q <= RW'(num_mag);
      ds_q  <= RW'(den_i) << (QW - 1);
      q_q   <= '0;
    end else if (busy_q) begin
      if (ge) rem_q <= rem_q - ds_q;
      ds_q <= ds_q >> 1;
      q_q  <= {q_q[QW-2:0], ge};
    end
  end

  // floor for negative dividends
  always_comb begin
    q_ext  = {1'b0, q_q};
    quot_o = neg_q ? $signed(-(q_ext + (QW+1)'(|rem_q))) : $signed(q_ext);
  end

  assign done_o = done_q;

endmodule

// ===== design/imu_motion_classifier_unit.sv =====
// channel   dir  fields (lowest bit up)
// s_axis    in   accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
// m_axis    out  led_color, motion_class
// cfg       in   register index, write data (19 bits)
//
// a calibration sample goes from idle straight to emit. a classified sample runs offset
// removal, scaling and a division per axis, squaring and classification, then emits only
// if it gives a result; the shared serial divider yields one quotient bit per cycle per axis.
// rst_ni clears the calibration sums and the previous class and loads the register defaults.
// a stalled m_axis holds the finished result; the next sample is still taken.
module imu_motion_classifier_unit #(
  parameter int CAL_SAMPLES = imc_pkg::DefCalSamples,
  parameter int FRAC_BITS   = imc_pkg::DefFracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // accel x, y, z, gyro x, y, z raw
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // led_color, motion_class, zero pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [18:0] cfg_data_i
);

  localparam int NW    = $clog2(CAL_SAMPLES + 1);
  localparam int SW    = 17 + NW;
  localparam int VW    = 18 + NW;
  localparam int KW    = 8 + FRAC_BITS;
  localparam int PW    = VW + KW + 1;
  localparam int NUMW  = PW + 2;
  localparam int DENW  = NW + 17;
  localparam int QW    = 13 + FRAC_BITS;
  localparam int VALW  = QW + 1;
  localparam int OPW   = (VALW + 1 > 21) ? VALW + 1 : 21;
  localparam int PRODW = 2 * OPW;
  localparam int SQW   = PRODW + 2;
  localparam int CMPW  = (VALW > imc_pkg::RegW) ? VALW : imc_pkg::RegW;
  localparam int GRAV  = (196 * (1 << FRAC_BITS) + 10) / 20;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_OFFS  = 8'b0000_0010,
    S_SCALE = 8'b0000_0100,
    S_START = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_SQ    = 8'b0010_0000,
    S_CLS   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [1:0]              gyro_sel_q, accel_sel_q;
  logic [imc_pkg::RegW-1:0] rot_thr_q, still_thr_q, grav_tol_q, tilt_tol_q, axis_thr_q;

  logic [NW-1:0]           cal_q;
  logic signed [SW-1:0]    sums_q [6];
  imc_pkg::motion_class_e  prev_q, pend_cls_q, cls;
  logic signed [15:0]      raw_q [6];
  logic signed [15:0]      in_raw [6];
  logic [2:0]              axis_q, sq_cnt_q;
  logic signed [VW-1:0]    v_q, v_d;
  logic signed [NUMW-1:0]  num_q;
  logic [DENW-1:0]         den_q, nd;
  logic [KW-1:0]           k;
  logic signed [PW-1:0]    prod;
  logic signed [VALW-1:0]  val_q [6];
  logic signed [VALW-1:0]  div_quot;
  logic                    div_done;
  logic signed [OPW-1:0]   azg_q, hi_q, lo_q, op;
  logic signed [PRODW-1:0] sqr;
  logic [SQW-1:0]          sq_acc_q, hi2_q, lo2_q, sq_mag;
  logic [CMPW-1:0]         gmag [3];
  logic [CMPW-1:0]         amag [3];
  logic                    accept, calibrating, rotating, near, still, tilted;
  logic                    out_free;

  assign accept        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign calibrating   = (cal_q < NW'(CAL_SAMPLES));
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    for (int i = 0; i < 6; i++) in_raw[i] = $signed(s_axis_tdata[16*i +: 16]);
  end

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_sel_q  <= '0;
      accel_sel_q <= '0;
      rot_thr_q   <= imc_pkg::RegW'(17920);
      still_thr_q <= imc_pkg::RegW'(1280);
      grav_tol_q  <= imc_pkg::RegW'(128);
      tilt_tol_q  <= imc_pkg::RegW'(26);
      axis_thr_q  <= imc_pkg::RegW'(256);
    end else if (cfg_valid_i) begin
      case (imc_pkg::cfg_reg_e'(cfg_index_i))
        imc_pkg::REG_GYRO_RANGE:  gyro_sel_q  <= cfg_data_i[1:0];
        imc_pkg::REG_ACCEL_RANGE: accel_sel_q <= cfg_data_i[1:0];
        imc_pkg::REG_ROTATE_THR:  rot_thr_q   <= cfg_data_i;
        imc_pkg::REG_STILL_THR:   still_thr_q <= cfg_data_i;
        imc_pkg::REG_GRAV_TOL:    grav_tol_q  <= cfg_data_i;
        imc_pkg::REG_TILT_TOL:    tilt_tol_q  <= cfg_data_i;
        imc_pkg::REG_AXIS_THR:    axis_thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // offset removal and scale factors
  always_comb begin
    v_d = VW'(raw_q[axis_q]) * $signed(VW'(CAL_SAMPLES)) - VW'(sums_q[axis_q]);
    if (axis_q >= 3'd3) begin
      k  = KW'(10) << FRAC_BITS;
      nd = DENW'(CAL_SAMPLES) * DENW'(imc_pkg::gyro_div(gyro_sel_q));
    end else begin
      k  = KW'(imc_pkg::accel_full_scale(accel_sel_q)) << FRAC_BITS;
      nd = DENW'(CAL_SAMPLES) << 15;
    end
    prod = v_q * $signed({1'b0, k});
  end

  imc_div #(
    .NUMW(NUMW),
    .DENW(DENW),
    .QW  (QW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == S_START),
    .num_i  (num_q),
    .den_i  (den_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // squaring operand select
  always_comb begin
    case (sq_cnt_q)
      3'd0: op = OPW'(val_q[0]);
      3'd1: op = OPW'(val_q[1]);
      3'd2: op = azg_q;
      3'd3: op = hi_q;
      default: op = lo_q;
    endcase
    sqr    = op * op;
    sq_mag = SQW'(unsigned'(sqr));
  end

  // classification
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gmag[i] = val_q[3+i][VALW-1] ? CMPW'(unsigned'(VALW'(-val_q[3+i])))
                                   : CMPW'(unsigned'(val_q[3+i]));
      amag[i] = val_q[i][VALW-1] ? CMPW'(unsigned'(VALW'(-val_q[i])))
                                 : CMPW'(unsigned'(val_q[i]));
    end
    rotating = (gmag[0] > CMPW'(rot_thr_q)) || (gmag[1] > CMPW'(rot_thr_q)) ||
               (gmag[2] > CMPW'(rot_thr_q));
    still    = (gmag[0] < CMPW'(still_thr_q)) && (gmag[1] < CMPW'(still_thr_q)) &&
               (gmag[2] < CMPW'(still_thr_q));
    near     = (sq_acc_q < hi2_q) && (lo_q[OPW-1] || (sq_acc_q > lo2_q));
    tilted   = amag[2] > CMPW'(tilt_tol_q);
    if (rotating) cls = imc_pkg::CLS_ROTATING;
    else if (near && still) cls = tilted ? imc_pkg::CLS_TILTED : imc_pkg::CLS_STILL;
    else if (amag[0] > CMPW'(axis_thr_q) && amag[1] < CMPW'(axis_thr_q))
      cls = imc_pkg::CLS_MOVE_X;
    else if (amag[1] > CMPW'(axis_thr_q) && amag[0] < CMPW'(axis_thr_q))
      cls = imc_pkg::CLS_MOVE_Y;
    else cls = imc_pkg::CLS_MOVING;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = calibrating ? S_EMIT : S_OFFS;
      S_OFFS:  state_d = S_SCALE;
      S_SCALE: state_d = S_START;
      S_START: state_d = S_DIV;
      S_DIV:   if (div_done) state_d = (axis_q == 3'd5) ? S_SQ : S_OFFS;
      S_SQ:    if (sq_cnt_q == 3'd4) state_d = S_CLS;
      S_CLS:   state_d = (cls == prev_q) ? S_EMIT : S_IDLE;
      S_EMIT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cal_q    <= '0;
      prev_q   <= imc_pkg::CLS_STILL;
      axis_q   <= '0;
      sq_cnt_q <= '0;
      for (int i = 0; i < 6; i++) sums_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && accept) begin
        axis_q <= '0;
        if (calibrating) begin
          cal_q <= cal_q + 1'b1;
          for (int i = 0; i < 6; i++) sums_q[i] <= sums_q[i] + SW'(in_raw[i]);
        end
      end
      if (state_q == S_DIV && div_done) begin
        axis_q   <= axis_q + 1'b1;
        sq_cnt_q <= '0;
      end
      if (state_q == S_SQ) sq_cnt_q <= sq_cnt_q + 1'b1;
      if (state_q == S_CLS) prev_q <= cls;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && accept) begin
      for (int i = 0; i < 6; i++) raw_q[i] <= in_raw[i];
      pend_cls_q <= imc_pkg::CLS_CALIB;
    end
    if (state_q == S_OFFS) v_q <= v_d;
    if (state_q == S_SCALE) begin
      num_q <= (NUMW'(prod) <<< 1) + $signed(NUMW'(nd));
      den_q <= nd << 1;
    end
    if (state_q == S_DIV && div_done) begin
      val_q[axis_q] <= div_quot;
      azg_q <= OPW'(val_q[2]) + OPW'(GRAV);
      hi_q  <= OPW'(GRAV) + OPW'(grav_tol_q);
      lo_q  <= OPW'(GRAV) - OPW'(grav_tol_q);
    end
    if (state_q == S_SQ) begin
      case (sq_cnt_q)
        3'd0: sq_acc_q <= sq_mag;
        3'd1, 3'd2: sq_acc_q <= sq_acc_q + sq_mag;
        3'd3: hi2_q <= sq_mag;
        default: lo2_q <= sq_mag;
      endcase
    end
    if (state_q == S_CLS) pend_cls_q <= cls;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (state_q == S_EMIT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_free) begin
      m_axis_tdata <= {2'b00, pend_cls_q, imc_pkg::color_of(pend_cls_q)};
    end
  end

  // checks
  a_cal_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_q <= NW'(CAL_SAMPLES))
    else $error("calibration count beyond sample count");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide phase");

  a_cal_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && accept && calibrating) |=>
      (pend_cls_q == imc_pkg::CLS_CALIB && state_q == S_EMIT))
    else $error("calibration sample without calibrating result");

endmodule
